// ===== rtl/rhsv_pkg.sv =====
`timescale 1ns / 1ps
// rhsv_pkg: shared types, constants and helpers for the RGB to HSV pipeline.
// No dependencies.
package rhsv_pkg;

  localparam int CH_W          = 8;
  localparam int SAT_NUM_W     = 16;
  localparam int HUE_NUM_W     = 14;
  localparam int QUO_W         = 8;
  localparam int DIV_STEPS     = 2;
  localparam int PREP_STAGES   = 2;

  localparam logic [CH_W-1:0] HUE_SCALE  = 8'd43;
  localparam logic [CH_W-1:0] BASE_RED   = 8'd0;
  localparam logic [CH_W-1:0] BASE_GREEN = 8'd85;
  localparam logic [CH_W-1:0] BASE_BLUE  = 8'd171;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } sel_t;

  typedef struct packed {
    logic [CH_W-1:0] bright;
    sel_t            sel;
    logic            neg;
    logic            gray;
  } side_t;

  function automatic logic [CH_W-1:0] hue_base(input sel_t sel);
    logic [CH_W-1:0] b;
    unique case (sel)
      SEL_RED:   b = BASE_RED;
      SEL_GREEN: b = BASE_GREEN;
      SEL_BLUE:  b = BASE_BLUE;
      default:   b = BASE_RED;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/rhsv_if.sv =====
`timescale 1ns / 1ps
// rhsv_if: valid/ready stream interfaces for RGB pixels in and HSV pixels out.
// Depends on rhsv_pkg.
interface rhsv_rgb_if;
  logic                   valid;
  logic                   ready;
  logic [rhsv_pkg::CH_W-1:0] red;
  logic [rhsv_pkg::CH_W-1:0] green;
  logic [rhsv_pkg::CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhsv_hsv_if;
  logic                   valid;
  logic                   ready;
  logic [rhsv_pkg::CH_W-1:0] hue;
  logic [rhsv_pkg::CH_W-1:0] saturation;
  logic [rhsv_pkg::CH_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// ===== rtl/rhsv_prep.sv =====
`timescale 1ns / 1ps
// rhsv_prep: two register stages: max/min, sector and difference, then the
// dividend products for saturation and hue. Depends on rhsv_pkg.
module rhsv_prep (
  input  logic                            clk,
  input  logic                            en,
  input  logic [rhsv_pkg::CH_W-1:0]       red,
  input  logic [rhsv_pkg::CH_W-1:0]       green,
  input  logic [rhsv_pkg::CH_W-1:0]       blue,
  output logic [rhsv_pkg::SAT_NUM_W-1:0]  num_sat,
  output logic [rhsv_pkg::HUE_NUM_W-1:0]  num_hue,
  output logic [rhsv_pkg::CH_W-1:0]       span,
  output rhsv_pkg::side_t                 side
);
  import rhsv_pkg::*;

  logic [CH_W-1:0] hi, lo, opa, opb;
  sel_t            sel;

  logic [CH_W-1:0] a_span, a_dabs;
  side_t           a_side;

  always_comb begin
    hi = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    priority if (hi == red) begin
      sel = SEL_RED;
      opa = green;
      opb = blue;
    end else if (hi == green) begin
      sel = SEL_GREEN;
      opa = blue;
      opb = red;
    end else begin
      sel = SEL_BLUE;
      opa = red;
      opb = green;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_span        <= hi - lo;
      a_dabs        <= (opa < opb) ? (opb - opa) : (opa - opb);
      a_side.bright <= hi;
      a_side.sel    <= sel;
      a_side.neg    <= opa < opb;
      a_side.gray   <= hi == lo;
    end
  end

  // 255 * span = (span << 8) - span
  always_ff @(posedge clk) begin
    if (en) begin
      num_sat <= {a_span, {CH_W{1'b0}}} - {{CH_W{1'b0}}, a_span};
      num_hue <= HUE_NUM_W'(a_dabs) * HUE_NUM_W'(HUE_SCALE);
      span    <= a_span;
      side    <= a_side;
    end
  end

endmodule

// ===== rtl/rhsv_divider.sv =====
`timescale 1ns / 1ps
// rhsv_divider: pipelined restoring divider, SPS quotient bits per stage.
// Requires num < den * 2**QW. Depends on nothing.
module rhsv_divider #(
  parameter int NW  = 16,
  parameter int DW  = 8,
  parameter int QW  = 8,
  parameter int SPS = 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);
  localparam int NS = QW / SPS;

  logic [DW-1:0] rem_r [NS];
  logic [QW-1:0] low_r [NS];
  logic [DW-1:0] den_r [NS];
  logic [QW-1:0] quo_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0] r_in, r_nx, d_in;
    logic [QW-1:0] l_in, l_nx, q_in, q_nx;
    logic [DW:0]   trial;

    if (s == 0) begin : g_first
      assign r_in = DW'(num >> QW);
      assign l_in = num[QW-1:0];
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_r[s-1];
      assign l_in = low_r[s-1];
      assign d_in = den_r[s-1];
      assign q_in = quo_r[s-1];
    end

    always_comb begin
      r_nx  = r_in;
      l_nx  = l_in;
      q_nx  = q_in;
      trial = '0;
      for (int k = 0; k < SPS; k++) begin
        trial = {r_nx, l_nx[QW-1]};
        l_nx  = {l_nx[QW-2:0], 1'b0};
        if (trial >= {1'b0, d_in}) begin
          r_nx = DW'(trial - {1'b0, d_in});
          q_nx = {q_nx[QW-2:0], 1'b1};
        end else begin
          r_nx = trial[DW-1:0];
          q_nx = {q_nx[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= r_nx;
        low_r[s] <= l_nx;
        den_r[s] <= d_in;
        quo_r[s] <= q_nx;
      end
    end
  end

  assign quo = quo_r[NS-1];

endmodule

// ===== rtl/rgb_to_hsv_8bit.sv =====
`timescale 1ns / 1ps
// rgb_to_hsv_8bit: 8-bit RGB to HSV converter, one pixel per cycle.
// Pipeline: two prep stages, the divider stages and one output register.
// Throughput: one transaction per clock unless stalled by pix_out.ready.
// Backpressure from pix_out.ready holds the whole pipeline in place.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// Depends on rhsv_pkg, rhsv_if, rhsv_prep, rhsv_divider.
module rgb_to_hsv_8bit #(
  parameter int STEPS_PER_STAGE = rhsv_pkg::DIV_STEPS
) (
  input  logic       clk,
  input  logic       rst,
  rhsv_rgb_if.sink   pix_in,
  rhsv_hsv_if.source pix_out
);
  import rhsv_pkg::*;

  localparam int NS     = QUO_W / STEPS_PER_STAGE;
  localparam int PIPE_D = PREP_STAGES + NS;

  logic                 adv;
  logic [PIPE_D-1:0]    vld;
  logic [SAT_NUM_W-1:0] num_sat;
  logic [HUE_NUM_W-1:0] num_hue;
  logic [CH_W-1:0]      span;
  side_t                side;
  side_t                side_d [NS];
  logic [QUO_W-1:0]     q_sat, q_hue;
  logic [CH_W-1:0]      offs;

  logic            out_valid;
  logic [CH_W-1:0] out_hue, out_sat, out_bright;

  assign adv          = !out_valid || pix_out.ready;
  assign pix_in.ready = adv;

  rhsv_prep u_prep (
    .clk     (clk),
    .en      (adv),
    .red     (pix_in.red),
    .green   (pix_in.green),
    .blue    (pix_in.blue),
    .num_sat (num_sat),
    .num_hue (num_hue),
    .span    (span),
    .side    (side)
  );

  rhsv_divider #(
    .NW  (SAT_NUM_W),
    .DW  (CH_W),
    .QW  (QUO_W),
    .SPS (STEPS_PER_STAGE)
  ) u_div_sat (
    .clk (clk),
    .en  (adv),
    .num (num_sat),
    .den (side.bright),
    .quo (q_sat)
  );

  rhsv_divider #(
    .NW  (HUE_NUM_W),
    .DW  (CH_W),
    .QW  (QUO_W),
    .SPS (STEPS_PER_STAGE)
  ) u_div_hue (
    .clk (clk),
    .en  (adv),
    .num (num_hue),
    .den (span),
    .quo (q_hue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_D-2:0], pix_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[0] <= side;
      for (int i = 1; i < NS; i++) side_d[i] <= side_d[i-1];
    end
  end

  // truncation toward zero: negate the magnitude quotient
  assign offs = side_d[NS-1].neg ? CH_W'(-q_hue) : CH_W'(q_hue);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[PIPE_D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_bright <= side_d[NS-1].bright;
      out_sat    <= (side_d[NS-1].bright == '0) ? '0 : CH_W'(q_sat);
      out_hue    <= side_d[NS-1].gray ? '0 : CH_W'(hue_base(side_d[NS-1].sel) + offs);
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.hue        = out_hue;
  assign pix_out.saturation = out_sat;
  assign pix_out.brightness = out_bright;

  a_black: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && pix_out.brightness == '0 |-> pix_out.hue == '0 && pix_out.saturation == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_gray: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && pix_out.saturation == '0 |-> pix_out.hue == '0)
    else $error("zero saturation with nonzero hue");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && pix_out.brightness != '0 && pix_out.hue != '0 |-> pix_out.saturation != '0)
    else $error("colored pixel with zero saturation");

  a_reset: assert property (@(posedge clk) rst |=> !pix_out.valid)
    else $error("output valid after reset");

endmodule
